// ----- design/json_value_validator_top_macros.svh -----
// Assertion macros for the JSON value validator.
// No dependencies; included by the modules that assert.
`ifndef JSON_VALUE_VALIDATOR_TOP_MACROS_SVH
`define JSON_VALUE_VALIDATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define JVV_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define JVV_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define JVV_ASSERT_IMP(lbl, clk, rst_n, a, b, msg)
`define JVV_ASSERT_NXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

// ----- design/jvv_pkg.sv -----
// Shared types and constants for the JSON value validator.
// No dependencies.
`default_nettype none
package jvv_pkg;
	localparam int NEST_LIMIT_DEF     = 32;
	localparam int MAX_TEXT_BYTES_DEF = 1048576;
	localparam int OFF_W              = 21;
	localparam int FIFO_DEPTH         = 4;

	typedef enum logic [4:0] {
		PH_VALUE, PH_ARR_FIRST, PH_OBJ_FIRST, PH_KEY, PH_COLON, PH_AFTER, PH_END,
		PH_STRV, PH_ESCV, PH_HEXV, PH_STRK, PH_ESCK, PH_HEXK, PH_LIT,
		PH_NSIGN, PH_NZERO, PH_NINT, PH_NDOT, PH_NFRAC, PH_NEXP, PH_NESIGN, PH_NEXPD
	} phase_t;

	// classified byte, front to back
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       is_ws;
		logic       is_dig;
		logic       is_hex;
		logic       is_esc;
	} cls_t;

	function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
		logic [7:0] r;
		r = 8'h00;
		case (kind)
			2'd0: case (pos)
				3'd0: r = "t"; 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e"; default: r = 8'h00;
			endcase
			2'd1: case (pos)
				3'd0: r = "n"; 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l"; default: r = 8'h00;
			endcase
			2'd2: case (pos)
				3'd0: r = "f"; 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s"; 3'd4: r = "e";
				default: r = 8'h00;
			endcase
			default: r = 8'h00;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- design/jvv_front.sv -----
// Front: accepts bytes and classifies them into a short queue.
// Depends on jvv_pkg.
`default_nettype none
module jvv_front import jvv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] text_byte,
	input  wire logic       last,
	input  wire logic       push,
	output logic            full,
	output logic            q_valid,
	output cls_t            q_data,
	input  wire logic       q_take
);
	localparam int AW = $clog2(FIFO_DEPTH);
	cls_t          mem_q [FIFO_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	cls_t          c;
	logic          wr, rd;

	always_comb begin
		c.ch     = text_byte;
		c.last   = last;
		c.is_ws  = (text_byte >= 8'd9 && text_byte <= 8'd13) || text_byte == 8'd32;
		c.is_dig = text_byte >= "0" && text_byte <= "9";
		c.is_hex = c.is_dig || (text_byte >= "a" && text_byte <= "f")
			|| (text_byte >= "A" && text_byte <= "F");
		c.is_esc = text_byte == "\"" || text_byte == "\\" || text_byte == "/"
			|| text_byte == "b" || text_byte == "f" || text_byte == "n"
			|| text_byte == "r" || text_byte == "t";
	end

	assign full    = cnt_q == (AW+1)'(FIFO_DEPTH);
	assign q_valid = cnt_q != '0;
	assign q_data  = mem_q[rd_q];
	assign wr      = push && !full;
	assign rd      = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wr_q <= wr_q + 1'b1;
			if (rd) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule
`default_nettype wire

// ----- design/jvv_back.sv -----
// Back: parser state machine, nesting stack and result register.
// Depends on jvv_pkg and the assertion macros header.
`default_nettype none
`include "json_value_validator_top_macros.svh"
module jvv_back import jvv_pkg::*; #(
	parameter int NEST_LIMIT     = NEST_LIMIT_DEF,
	parameter int MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  cls_t            q_data,
	output logic            q_take,
	output logic            empty,
	input  wire logic       pop,
	output logic            valid_res,
	output logic [OFF_W-1:0] stop_offset
);
	localparam int SD = NEST_LIMIT + 1;
	localparam int DW = $clog2(NEST_LIMIT + 2);
	localparam int CW = $clog2(MAX_TEXT_BYTES + 1);

	logic [SD-1:0] stk_q;
	logic [DW-1:0] dep_q;
	phase_t        ph_q;
	logic [1:0]    lk_q;
	logic [2:0]    lp_q;
	logic [2:0]    hx_q;
	logic [CW-1:0] bc_q, fa_q;
	logic          ff_q, te_q;
	logic          rv_q, rres_q;
	logic [OFF_W-1:0] roff_q;

	logic [SD-1:0] stk_d;
	logic [DW-1:0] dep_d;
	phase_t        ph_d;
	logic [1:0]    lk_d;
	logic [2:0]    lp_d, hx_d;
	logic          fail, act, deep, top_obj, numend, vld;
	phase_t        p2;
	logic [7:0]    ch;

	assign q_take = q_valid && (!rv_q || pop);
	assign empty  = !rv_q;
	assign valid_res   = rres_q;
	assign stop_offset = roff_q;
	assign ch   = q_data.ch;
	assign act  = q_take && !te_q && !ff_q && ch != 8'h00;
	assign deep = dep_q > DW'(NEST_LIMIT);
	assign top_obj = dep_q != '0 && !(dep_q - 1'b1 > DW'(NEST_LIMIT)) && stk_q[dep_q - 1'b1];

	function automatic phase_t done_ph(input logic [DW-1:0] d);
		return (d != '0) ? PH_AFTER : PH_END;
	endfunction

	always_comb begin
		stk_d = stk_q; dep_d = dep_q; lk_d = lk_q; lp_d = lp_q; hx_d = hx_q;
		fail = 1'b0; numend = 1'b0;
		// number terminators re-handle the byte in the done phase
		p2 = ph_q;
		case (ph_q)
			PH_NZERO, PH_NINT: if (!(ph_q == PH_NINT && q_data.is_dig) && ch != "."
				&& ch != "e" && ch != "E") numend = 1'b1;
			PH_NFRAC: if (!q_data.is_dig && ch != "e" && ch != "E") numend = 1'b1;
			PH_NEXPD: if (!q_data.is_dig) numend = 1'b1;
			default: ;
		endcase
		if (numend) p2 = done_ph(dep_q);
		ph_d = p2;
		case (p2)
			PH_VALUE, PH_ARR_FIRST: begin
				if (q_data.is_ws) ;
				else if (p2 == PH_ARR_FIRST && ch == "]") begin
					if (dep_q != '0) dep_d = dep_q - 1'b1;
					ph_d = done_ph(dep_d);
				end else if (deep) fail = 1'b1;
				else if (ch == "\"") ph_d = PH_STRV;
				else if (ch == "{" || ch == "[") begin
					stk_d[dep_q[DW-1:0]] = ch == "{";
					dep_d = dep_q + 1'b1;
					ph_d = (ch == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
				end else if (ch == "t") begin lk_d = 2'd0; lp_d = 3'd1; ph_d = PH_LIT; end
				else if (ch == "n") begin lk_d = 2'd1; lp_d = 3'd1; ph_d = PH_LIT; end
				else if (ch == "f") begin lk_d = 2'd2; lp_d = 3'd1; ph_d = PH_LIT; end
				else if (ch == "-") ph_d = PH_NSIGN;
				else if (ch == "0") ph_d = PH_NZERO;
				else if (q_data.is_dig) ph_d = PH_NINT;
				else fail = 1'b1;
			end
			PH_OBJ_FIRST, PH_KEY: begin
				if (q_data.is_ws) ;
				else if (p2 == PH_OBJ_FIRST && ch == "}") begin
					if (dep_q != '0) dep_d = dep_q - 1'b1;
					ph_d = done_ph(dep_d);
				end else if (deep || ch != "\"") fail = 1'b1;
				else ph_d = PH_STRK;
			end
			PH_COLON: if (!q_data.is_ws) begin
				if (ch == ":") ph_d = PH_VALUE; else fail = 1'b1;
			end
			PH_AFTER: if (!q_data.is_ws) begin
				if (ch == ",") ph_d = top_obj ? PH_KEY : PH_VALUE;
				else if (ch == (top_obj ? 8'h7d : 8'h5d)) begin
					if (dep_q != '0) dep_d = dep_q - 1'b1;
					ph_d = done_ph(dep_d);
				end else fail = 1'b1;
			end
			PH_END: if (!q_data.is_ws) fail = 1'b1;
			PH_STRV, PH_STRK: begin
				if (ch == "\"") ph_d = (p2 == PH_STRK) ? PH_COLON : done_ph(dep_q);
				else if (ch == "\\") ph_d = (p2 == PH_STRK) ? PH_ESCK : PH_ESCV;
				else if (ch < 8'd32) fail = 1'b1;
			end
			PH_ESCV, PH_ESCK: begin
				if (ch == "u") begin
					hx_d = 3'd4; ph_d = (p2 == PH_ESCK) ? PH_HEXK : PH_HEXV;
				end else if (!q_data.is_esc) fail = 1'b1;
				else ph_d = (p2 == PH_ESCK) ? PH_STRK : PH_STRV;
			end
			PH_HEXV, PH_HEXK: begin
				if (!q_data.is_hex) fail = 1'b1;
				else begin
					if (hx_q != '0) hx_d = hx_q - 1'b1;
					if (hx_d == '0) ph_d = (p2 == PH_HEXK) ? PH_STRK : PH_STRV;
				end
			end
			PH_LIT: begin
				if (lk_q > 2'd2 || lp_q >= ((lk_q == 2'd2) ? 3'd5 : 3'd4)
					|| ch != lit_char(lk_q, lp_q)) fail = 1'b1;
				else if (lp_q + 1'b1 == ((lk_q == 2'd2) ? 3'd5 : 3'd4)) begin
					lk_d = 2'd0; lp_d = 3'd0; ph_d = done_ph(dep_q);
				end else lp_d = lp_q + 1'b1;
			end
			PH_NSIGN: begin
				if (ch == "0") ph_d = PH_NZERO;
				else if (q_data.is_dig) ph_d = PH_NINT;
				else fail = 1'b1;
			end
			PH_NZERO, PH_NINT: begin
				if (ch == ".") ph_d = PH_NDOT;
				else if (ch == "e" || ch == "E") ph_d = PH_NEXP;
			end
			PH_NDOT: if (q_data.is_dig) ph_d = PH_NFRAC; else fail = 1'b1;
			PH_NFRAC: if (ch == "e" || ch == "E") ph_d = PH_NEXP;
			PH_NEXP: begin
				if (ch == "+" || ch == "-") ph_d = PH_NESIGN;
				else if (q_data.is_dig) ph_d = PH_NEXPD;
				else fail = 1'b1;
			end
			PH_NESIGN: if (q_data.is_dig) ph_d = PH_NEXPD; else fail = 1'b1;
			PH_NEXPD: ;
			default: fail = 1'b1;
		endcase
		vld = ph_q == PH_END || (dep_q == '0 && (ph_q == PH_NZERO || ph_q == PH_NINT
			|| ph_q == PH_NFRAC || ph_q == PH_NEXPD));
	end

	logic          ff_n;
	logic [CW-1:0] fa_n, bc_n;
	logic          v_n;
	always_comb begin
		ff_n = ff_q; fa_n = fa_q; bc_n = bc_q;
		if (act) begin
			if (bc_q < CW'(MAX_TEXT_BYTES)) bc_n = bc_q + 1'b1;
			if (fail) begin ff_n = 1'b1; fa_n = bc_q; end
		end
		// verdict from state after this byte
		v_n = !ff_n && (act ? (ph_d == PH_END || (dep_d == '0 && (ph_d == PH_NZERO
			|| ph_d == PH_NINT || ph_d == PH_NFRAC || ph_d == PH_NEXPD))) : vld);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stk_q <= '0; dep_q <= '0; ph_q <= PH_VALUE; lk_q <= '0; lp_q <= '0; hx_q <= '0;
			bc_q <= '0; fa_q <= '0; ff_q <= 1'b0; te_q <= 1'b0; rv_q <= 1'b0;
		end else begin
			if (rv_q && pop) rv_q <= 1'b0;
			if (q_take) begin
				if (q_data.last) begin
					stk_q <= '0; dep_q <= '0; ph_q <= PH_VALUE; lk_q <= '0; lp_q <= '0;
					hx_q <= '0; bc_q <= '0; fa_q <= '0; ff_q <= 1'b0; te_q <= 1'b0;
					rv_q <= 1'b1;
				end else begin
					if (!te_q && !ff_q && ch == 8'h00) te_q <= 1'b1;
					if (act) begin
						stk_q <= stk_d; dep_q <= dep_d; ph_q <= ph_d; lk_q <= lk_d;
						lp_q <= lp_d; hx_q <= hx_d;
					end
					bc_q <= bc_n; fa_q <= fa_n; ff_q <= ff_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_take && q_data.last) begin
			rres_q <= v_n;
			roff_q <= OFF_W'(ff_n ? fa_n : bc_n);
		end
	end

	`JVV_ASSERT_IMP(a_dep_bound, clk, arst_n, 1'b1, dep_q <= DW'(NEST_LIMIT + 1), "depth overflow")
	`JVV_ASSERT_IMP(a_fail_pos, clk, arst_n, ff_q, fa_q < bc_q || bc_q == CW'(MAX_TEXT_BYTES), "fail index past count")
	`JVV_ASSERT_NXT(a_res_load, clk, arst_n, q_take && q_data.last, !empty, "result not loaded")
	`JVV_ASSERT_IMP(a_no_take, clk, arst_n, !empty && !pop, !q_take, "took item over held result")
endmodule
`default_nettype wire

// ----- design/json_value_validator_top.sv -----
// Top level of the JSON value validator.
// Depends on jvv_pkg, jvv_front and jvv_back.
//
// Checks that a byte stream is exactly one JSON value with optional whitespace around it.
// One byte is taken per cycle while full is low; a front stage classifies each byte
// into a four-entry queue, and the back parser consumes one queued byte per cycle unless
// stalled. A result is delivered on the byte marked last; the parser then returns to its
// start state. The parser takes a queued byte only while the result register is free or
// being popped in the same cycle, so an unpopped result stalls the parser; the queue
// then absorbs up to four bytes before full rises. With an empty queue and a free result
// register, the last byte passes a queue entry and then the result register. A zero byte
// ends the text; bytes after it or after a fault are ignored until last. stop_offset gives
// the offending byte index or text length and saturates at MAX_TEXT_BYTES.
`default_nettype none
module json_value_validator_top import jvv_pkg::*; #(
	parameter int NEST_LIMIT     = NEST_LIMIT_DEF,
	parameter int MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       text_byte,
	input  wire logic             last,
	input  wire logic             push,
	output logic                  full,
	output logic                  empty,
	input  wire logic             pop,
	output logic                  valid_res,
	output logic [OFF_W-1:0]      stop_offset
);
	logic q_valid, q_take;
	cls_t q_data;

	jvv_front u_front (
		.clk, .arst_n, .text_byte, .last, .push, .full,
		.q_valid, .q_data, .q_take
	);

	jvv_back #(.NEST_LIMIT(NEST_LIMIT), .MAX_TEXT_BYTES(MAX_TEXT_BYTES)) u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_take, .empty, .pop, .valid_res, .stop_offset
	);
endmodule
`default_nettype wire
